@@ hw/rtl/keypad_integer_calculator_macros.svh @@
// ----------------------------------------------------------------------------
// Keypad integer calculator assertion macros
// Short forms for clocked assertions with the asynchronous reset as disable.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_INTEGER_CALCULATOR_MACROS_SVH
`define KEYPAD_INTEGER_CALCULATOR_MACROS_SVH

// Same-cycle implication.
`define KIC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/kic_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator package
// Key codes, pending operation codes, beat types and controller interface.
// ----------------------------------------------------------------------------
package kic_pkg;

	typedef enum logic [2:0] {
		CMD_DIGIT  = 3'd0,
		CMD_CLEAR  = 3'd1,
		CMD_ALLCLR = 3'd2,
		CMD_ADD    = 3'd3,
		CMD_SUB    = 3'd4,
		CMD_MUL    = 3'd5,
		CMD_DIV    = 3'd6,
		CMD_EQ     = 3'd7
	} cmd_t;

	// Pending operation uses the operator key codes; zero means none pending.
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd3,
		OP_SUB  = 3'd4,
		OP_MUL  = 3'd5,
		OP_DIV  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUSY,
		S_COMMIT
	} state_t;

	localparam logic CFG_NUMBER_BASE = 1'b0;
	localparam logic CFG_WORD_SIZE   = 1'b1;

	localparam logic [1:0] WS_8  = 2'd0;
	localparam logic [1:0] WS_16 = 2'd1;
	localparam logic [1:0] WS_32 = 2'd2;
	localparam logic [1:0] WS_64 = 2'd3;

	localparam logic [4:0] NUMBER_BASE_RESET = 5'd10;
	localparam logic [1:0] WORD_SIZE_RESET   = 2'd3;

	typedef struct packed {
		cmd_t       command;
		logic [3:0] digit;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] shown_value;
		logic               divide_error;
	} out_item_t;

	typedef struct packed {
		logic digit_en;     // append digit to entry, show it
		logic clear_entry;  // clear entry, show zero
		logic clear_acc;    // clear accumulator
		logic move_entry;   // accumulator takes entry, entry cleared
		logic start;        // load the iterative multiply/divide unit
		logic step;         // one bit of multiply/divide
		logic commit;       // write the pending operation result
		logic out_load;     // load the output register
		op_t  op;           // pending operation
	} dp_cmd_t;

	typedef struct packed {
		logic done;         // the current step is the last one
	} dp_sts_t;

endpackage

@@ hw/rtl/kic_datapath.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator datapath
// Config registers, accumulator, entry, shift-add multiplier, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module kic_datapath #(
	parameter int WORD_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic [3:0]         digit,
	input  kic_pkg::dp_cmd_t   dp_cmd,
	output kic_pkg::dp_sts_t   dp_sts,
	output kic_pkg::out_item_t out_item
);

	localparam int W  = WORD_WIDTH;
	localparam int CW = $clog2(W);
	localparam int W8  = (8 < W) ? 8 : W;
	localparam int W16 = (16 < W) ? 16 : W;
	localparam int W32 = (32 < W) ? 32 : W;

	logic [4:0]    number_base_q;
	logic [1:0]    word_size_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  entry_q;
	logic [W-1:0]  wk_a_q;   // multiplier, or dividend shifting into quotient
	logic [W-1:0]  wk_b_q;   // multiplicand, or divisor
	logic [W-1:0]  wk_r_q;   // product, or remainder
	logic          neg_q;
	logic          dz_q;
	logic [CW-1:0] cnt_q;
	kic_pkg::out_item_t out_q;

	// Sign-extends from the active word size, kept within the storage width.
	function automatic logic [W-1:0] sext_w(input logic [W-1:0] v, input logic [1:0] ws);
		logic [W-1:0] r;
		logic [6:0]   wid;
		logic         sgn;
		case (ws)
			kic_pkg::WS_8: begin
				wid = 7'(W8);
				sgn = v[W8-1];
			end
			kic_pkg::WS_16: begin
				wid = 7'(W16);
				sgn = v[W16-1];
			end
			kic_pkg::WS_32: begin
				wid = 7'(W32);
				sgn = v[W32-1];
			end
			default: begin
				wid = 7'(W);
				sgn = v[W-1];
			end
		endcase
		for (int i = 0; i < W; i++) begin
			r[i] = (i < int'(wid)) ? v[i] : sgn;
		end
		return r;
	endfunction

	logic [W-1:0] digit_prod;
	logic [W-1:0] entry_next;
	logic [W-1:0] a_ext;
	logic [W-1:0] b_ext;
	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W:0]   div_shift;
	logic [W:0]   div_trial;
	logic [W-1:0] res_raw;
	logic [W-1:0] res;
	logic         res_err;
	logic signed [W-1:0] shown_w;

	always_comb begin
		digit_prod = entry_q * W'(number_base_q);
		entry_next = sext_w(digit_prod + W'(digit), word_size_q);

		a_ext = sext_w(acc_q, word_size_q);
		b_ext = sext_w(entry_q, word_size_q);
		a_mag = a_ext[W-1] ? (~a_ext + W'(1)) : a_ext;
		b_mag = b_ext[W-1] ? (~b_ext + W'(1)) : b_ext;

		div_shift = {wk_r_q, wk_a_q[W-1]};
		div_trial = div_shift - {1'b0, wk_b_q};

		res_err = 1'b0;
		case (dp_cmd.op)
			kic_pkg::OP_ADD: res_raw = acc_q + entry_q;
			kic_pkg::OP_SUB: res_raw = acc_q - entry_q;
			kic_pkg::OP_MUL: res_raw = wk_r_q;
			kic_pkg::OP_DIV: begin
				res_err = dz_q;
				if (dz_q) begin
					res_raw = '0;
				end else begin
					res_raw = neg_q ? (~wk_a_q + W'(1)) : wk_a_q;
				end
			end
			default: res_raw = '0;
		endcase
		// Low bits of add, sub and mul depend only on low operand bits.
		res = sext_w(res_raw, word_size_q);
	end

	assign dp_sts.done = (cnt_q == CW'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= kic_pkg::NUMBER_BASE_RESET;
			word_size_q   <= kic_pkg::WORD_SIZE_RESET;
			acc_q         <= '0;
			entry_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kic_pkg::CFG_NUMBER_BASE: number_base_q <= cfg_data;
					kic_pkg::CFG_WORD_SIZE:   word_size_q   <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (dp_cmd.digit_en) begin
				entry_q <= entry_next;
			end
			if (dp_cmd.clear_entry) begin
				entry_q <= '0;
			end
			if (dp_cmd.clear_acc) begin
				acc_q <= '0;
			end
			if (dp_cmd.move_entry) begin
				acc_q   <= entry_q;
				entry_q <= '0;
			end
			if (dp_cmd.commit) begin
				acc_q   <= res;
				entry_q <= '0;
			end
		end
	end

	// Iterative unit: one product or quotient bit per step.
	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			cnt_q <= '0;
			if (dp_cmd.op == kic_pkg::OP_DIV) begin
				wk_a_q <= a_mag;
				wk_b_q <= b_mag;
				wk_r_q <= '0;
				neg_q  <= a_ext[W-1] ^ b_ext[W-1];
				dz_q   <= (b_mag == '0);
			end else begin
				wk_a_q <= entry_q;
				wk_b_q <= acc_q;
				wk_r_q <= '0;
				neg_q  <= 1'b0;
				dz_q   <= 1'b0;
			end
		end else if (dp_cmd.step) begin
			cnt_q <= cnt_q + CW'(1);
			if (dp_cmd.op == kic_pkg::OP_DIV) begin
				if (!div_trial[W]) begin
					wk_r_q <= div_trial[W-1:0];
					wk_a_q <= {wk_a_q[W-2:0], 1'b1};
				end else begin
					wk_r_q <= div_shift[W-1:0];
					wk_a_q <= {wk_a_q[W-2:0], 1'b0};
				end
			end else begin
				if (wk_a_q[0]) begin
					wk_r_q <= wk_r_q + wk_b_q;
				end
				wk_a_q <= {1'b0, wk_a_q[W-1:1]};
				wk_b_q <= {wk_b_q[W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (dp_cmd.digit_en) begin
			shown_w = entry_next;
		end else if (dp_cmd.commit) begin
			shown_w = res;
		end else begin
			shown_w = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			out_q.shown_value  <= 64'(shown_w);
			out_q.divide_error <= dp_cmd.commit & res_err;
		end
	end

	assign out_item = out_q;

endmodule

@@ hw/rtl/kic_controller.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator controller
// Decodes keys, tracks the pending operation, sequences the iterative unit
// and owns the handshakes.
// ----------------------------------------------------------------------------
module kic_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kic_pkg::cmd_t    command,
	output logic             out_valid,
	input  logic             out_ready,
	input  kic_pkg::dp_sts_t dp_sts,
	output kic_pkg::dp_cmd_t dp_cmd
);

	kic_pkg::state_t state_q, state_d;
	kic_pkg::op_t    pending_q, pending_d;
	kic_pkg::cmd_t   cmd_q, cmd_d;
	logic            out_valid_q;

	kic_pkg::op_t    op_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kic_pkg::S_IDLE;
			pending_q   <= kic_pkg::OP_NONE;
			cmd_q       <= kic_pkg::CMD_DIGIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
			cmd_q     <= cmd_d;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		cmd_d     = cmd_q;
		dp_cmd    = '0;
		dp_cmd.op = pending_q;
		in_ready  = 1'b0;
		// Equals leaves nothing pending; an operator key becomes the new pending one.
		op_after  = (command == kic_pkg::CMD_EQ) ? kic_pkg::OP_NONE : kic_pkg::op_t'(command);

		case (state_q)
			kic_pkg::S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					case (command)
						kic_pkg::CMD_DIGIT: begin
							dp_cmd.digit_en = 1'b1;
							dp_cmd.out_load = 1'b1;
						end
						kic_pkg::CMD_CLEAR: begin
							dp_cmd.clear_entry = 1'b1;
							dp_cmd.out_load    = 1'b1;
						end
						kic_pkg::CMD_ALLCLR: begin
							dp_cmd.clear_entry = 1'b1;
							dp_cmd.clear_acc   = 1'b1;
							dp_cmd.out_load    = 1'b1;
							pending_d          = kic_pkg::OP_NONE;
						end
						kic_pkg::CMD_ADD, kic_pkg::CMD_SUB, kic_pkg::CMD_MUL,
						kic_pkg::CMD_DIV, kic_pkg::CMD_EQ: begin
							case (pending_q)
								kic_pkg::OP_NONE: begin
									if (command != kic_pkg::CMD_EQ) begin
										dp_cmd.move_entry = 1'b1;
										pending_d         = op_after;
									end
								end
								kic_pkg::OP_ADD, kic_pkg::OP_SUB: begin
									dp_cmd.commit   = 1'b1;
									dp_cmd.out_load = 1'b1;
									pending_d       = op_after;
								end
								default: begin
									dp_cmd.start = 1'b1;
									cmd_d        = command;
									state_d      = kic_pkg::S_BUSY;
								end
							endcase
						end
						default: ;
					endcase
				end
			end
			kic_pkg::S_BUSY: begin
				dp_cmd.step = 1'b1;
				if (dp_sts.done) begin
					state_d = kic_pkg::S_COMMIT;
				end
			end
			kic_pkg::S_COMMIT: begin
				dp_cmd.commit   = 1'b1;
				dp_cmd.out_load = 1'b1;
				pending_d = (cmd_q == kic_pkg::CMD_EQ) ? kic_pkg::OP_NONE
					: kic_pkg::op_t'(cmd_q);
				state_d   = kic_pkg::S_IDLE;
			end
			default: state_d = kic_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/keypad_integer_calculator.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator
// Four-function programmer calculator taking one key per beat.
// ----------------------------------------------------------------------------
// Digit, C, AC, add, sub, equals and an operator key with nothing pending
// are each handled as the key is taken. A pending multiply or divide runs through a shared
// shift-add / restoring-divide unit that produces one bit per cycle, so such
// a key holds off the next key until every bit is produced and the result is
// committed. A new key is taken as the previous result beat leaves the
// output register, or while that register is empty.
module keypad_integer_calculator #(
	parameter int WORD_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  kic_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output kic_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data
);

`include "keypad_integer_calculator_macros.svh"

	kic_pkg::dp_cmd_t dp_cmd;
	kic_pkg::dp_sts_t dp_sts;

	kic_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (in_item.command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_sts    (dp_sts),
		.dp_cmd    (dp_cmd)
	);

	kic_datapath #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.digit     (in_item.digit),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts),
		.out_item  (out_item)
	);

	`KIC_ASSERT_NOW(a_no_take_while_held, out_valid && !out_ready, !in_ready, "taken while held")
	`KIC_ASSERT_NEXT(a_start_busy, dp_cmd.start, !in_ready && dp_cmd.step, "no step after start")
	`KIC_ASSERT_NEXT(a_last_step_commit, dp_cmd.step && dp_sts.done, dp_cmd.commit, "no commit")
	`KIC_ASSERT_NOW(a_err_zero, out_item.divide_error, out_item.shown_value == '0, "error value")

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator testbench
// Sends key beats to the calculator and keeps its own running copy of the
// accumulator, entry value, pending operation and both registers. Every
// displayed value and divide error flag is checked in order while the sender
// pauses in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;
	import kic_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 80;
	localparam int STALL_LIMIT    = 2000;
	localparam int RANDOM_PHASES  = 12;
	localparam int KEYS_PER_PHASE = 125;
	localparam int MAX_REPORTS    = 10;

	localparam int RX_OPEN  = 0;
	localparam int RX_COIN  = 1;
	localparam int RX_CHOKE = 2;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_item   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_item;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = 1'b0;
	logic [4:0] cfg_data  = '0;

	// Running copy of the calculator.
	logic [4:0]  m_base  = NUMBER_BASE_RESET;
	logic [1:0]  m_wsize = WORD_SIZE_RESET;
	logic [63:0] m_acc   = '0;
	logic [63:0] m_entry = '0;
	op_t         m_op    = OP_NONE;

	out_item_t   shown_fifo[$];
	out_item_t   want_item;
	int unsigned fail_count   = 0;
	int unsigned keys_sent    = 0;
	int unsigned burst_left   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rx_cycle     = 0;
	int unsigned rx_mode      = RX_OPEN;
	int unsigned rx_run       = 0;
	logic        rx_level     = 1'b1;

	keypad_integer_calculator u_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_item,
		.out_valid,
		.out_ready,
		.out_item,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic logic [63:0] fit_word(input logic [63:0] v);
		case (m_wsize)
			WS_8:    return {{56{v[7]}}, v[7:0]};
			WS_16:   return {{48{v[15]}}, v[15:0]};
			WS_32:   return {{32{v[31]}}, v[31:0]};
			default: return v;
		endcase
	endfunction

	// Applies the pending operation to accumulator and entry in the word size.
	task automatic run_pending();
		logic [63:0] a, b, mag_a, mag_b, quot, res;
		out_item_t   shown;
		a = fit_word(m_acc);
		b = fit_word(m_entry);
		mag_a = a[63] ? 64'd0 - a : a;
		mag_b = b[63] ? 64'd0 - b : b;
		shown.divide_error = 1'b0;
		case (m_op)
			OP_ADD: res = a + b;
			OP_SUB: res = a - b;
			OP_MUL: res = a * b;
			default: begin
				if (b == 64'd0) begin
					res = '0;
					shown.divide_error = 1'b1;
				end else begin
					quot = mag_a / mag_b;
					res = (a[63] ^ b[63]) ? 64'd0 - quot : quot;
				end
			end
		endcase
		m_acc = fit_word(res);
		m_entry = '0;
		shown.shown_value = m_acc;
		shown_fifo.push_back(shown);
	endtask

	task automatic calc_key(input cmd_t key, input logic [3:0] dig);
		out_item_t shown;
		shown = '0;
		case (key)
			CMD_DIGIT: begin
				m_entry = fit_word(fit_word(m_entry) * 64'(m_base) + 64'(dig));
				shown.shown_value = m_entry;
				shown_fifo.push_back(shown);
			end
			CMD_CLEAR: begin
				m_entry = '0;
				shown_fifo.push_back(shown);
			end
			CMD_ALLCLR: begin
				m_acc = '0;
				m_entry = '0;
				m_op = OP_NONE;
				shown_fifo.push_back(shown);
			end
			CMD_EQ: begin
				if (m_op != OP_NONE) begin
					run_pending();
					m_op = OP_NONE;
				end
			end
			default: begin
				// The first operator of a chain only parks the entry.
				if (m_op == OP_NONE) begin
					m_acc = m_entry;
					m_entry = '0;
				end else begin
					run_pending();
				end
				m_op = op_t'(key);
			end
		endcase
	endtask

	task automatic press(input cmd_t key, input logic [3:0] dig);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		in_item <= '{command: key, digit: dig};
		do @(posedge clk); while (!in_ready);
		burst_left--;
		keys_sent++;
		calc_key(key, dig);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shown_fifo.size() != 0) @(negedge clk);
	endtask

	// A parked operator gives no beat, so allow a full multiply/divide after the last one.
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUMBER_BASE)
			m_base = val;
		else
			m_wsize = val[1:0];
	endtask

	task automatic enter_number();
		int unsigned len, roll, span;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			len = 0;
		else if (roll < 70)
			len = $urandom_range(1, 3);
		else if (roll < 90)
			len = $urandom_range(4, 8);
		else
			len = $urandom_range(9, 24);
		span = (m_base >= 2 && m_base <= 16) ? m_base : 16;
		repeat (len)
			press(CMD_DIGIT, ($urandom_range(0, 9) == 0) ? 4'($urandom)
				: 4'($urandom_range(0, span - 1)));
	endtask

	task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s: expected value %0d error %0b, got value %0d error %0b",
				$time, what, want.shown_value, want.divide_error,
				got.shown_value, got.divide_error);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (shown_fifo.size() == 0) begin
				note_mismatch("result beat with nothing expected", '0, out_item);
			end else begin
				want_item = shown_fifo.pop_front();
				if (want_item.shown_value !== out_item.shown_value)
					note_mismatch("shown_value differs", want_item, out_item);
				else if (want_item.divide_error !== out_item.divide_error)
					note_mismatch("divide_error differs", want_item, out_item);
			end
		end
	end

	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 300 == 0)
			rx_mode = $urandom_range(RX_OPEN, RX_CHOKE);
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			default: begin
				if (rx_run == 0) begin
					rx_level = !rx_level;
					rx_run = rx_level ? $urandom_range(1, 4) : $urandom_range(1, 16);
				end else begin
					rx_run--;
				end
				out_ready <= rx_level;
			end
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Reset registers: base 10, 64-bit words.
	task automatic test_key_entry();
		press(CMD_DIGIT, 4'd9);
		press(CMD_DIGIT, 4'd15);
		press(CMD_CLEAR, 4'd0);
		press(CMD_DIGIT, 4'd4);
		press(CMD_SUB, 4'd0);
		press(CMD_DIGIT, 4'd2);
		press(CMD_MUL, 4'd0);
		press(CMD_DIGIT, 4'd8);
		press(CMD_DIGIT, 4'd0);
		press(CMD_EQ, 4'd0);
		press(CMD_EQ, 4'd15);
	endtask

	task automatic test_corner_cases();
		settle();
		write_reg(CFG_NUMBER_BASE, 5'd16);
		write_reg(CFG_WORD_SIZE, {3'b000, WS_8});
		// 127 + 1 wraps to the most negative byte, which is then divided by -1.
		press(CMD_DIGIT, 4'd7);
		press(CMD_DIGIT, 4'd15);
		press(CMD_ADD, 4'd0);
		press(CMD_DIGIT, 4'd1);
		press(CMD_DIV, 4'd0);
		press(CMD_DIGIT, 4'd15);
		press(CMD_DIGIT, 4'd15);
		press(CMD_EQ, 4'd0);
		press(CMD_DIGIT, 4'd5);
		press(CMD_DIV, 4'd0);
		press(CMD_EQ, 4'd0);

		// An entry made at 16 bits is cut back to 8 bits when next used.
		settle();
		write_reg(CFG_WORD_SIZE, {3'b111, WS_16});
		press(CMD_DIGIT, 4'd1);
		press(CMD_DIGIT, 4'd2);
		press(CMD_DIGIT, 4'd3);
		settle();
		write_reg(CFG_WORD_SIZE, {3'b000, WS_8});
		press(CMD_ADD, 4'd0);
		press(CMD_DIGIT, 4'd1);
		press(CMD_EQ, 4'd0);

		// A zero base makes the entry just the last digit.
		settle();
		write_reg(CFG_NUMBER_BASE, 5'd0);
		press(CMD_DIGIT, 4'd9);
		press(CMD_DIGIT, 4'd15);

		// All clear must leave the registers as written.
		settle();
		write_reg(CFG_NUMBER_BASE, 5'd31);
		write_reg(CFG_WORD_SIZE, {3'b000, WS_64});
		press(CMD_ALLCLR, 4'd0);
		press(CMD_DIGIT, 4'd1);
		press(CMD_DIGIT, 4'd3);
	endtask

	task automatic test_random_keys();
		logic [4:0]  base;
		int unsigned phase_end;
		int unsigned operands;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case (phase)
				0: base = 5'd2;
				1: base = 5'd16;
				2: base = 5'd0;
				3: base = 5'd31;
				4: base = 5'd1;
				default: base = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(2, 16));
			endcase
			write_reg(CFG_NUMBER_BASE, base);
			write_reg(CFG_WORD_SIZE, {3'($urandom), 2'(phase)});
			phase_end = keys_sent + KEYS_PER_PHASE;
			while (keys_sent < phase_end) begin
				if ($urandom_range(0, 99) < 85) begin
					if ($urandom_range(0, 4) == 0)
						press(CMD_ALLCLR, 4'($urandom));
					operands = $urandom_range(1, 4);
					for (int k = 0; k < operands; k++) begin
						enter_number();
						if ($urandom_range(0, 9) == 0)
							press(CMD_CLEAR, 4'($urandom));
						if (k == operands - 1 && $urandom_range(0, 4) != 0)
							press(CMD_EQ, 4'($urandom));
						else
							press(cmd_t'($urandom_range(CMD_ADD, CMD_DIV)), 4'($urandom));
					end
				end else begin
					press(cmd_t'($urandom_range(0, 7)), 4'($urandom));
				end
				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_key_entry();
		test_corner_cases();
		test_random_keys();
		settle();
		if (fail_count == 0 && shown_fifo.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
